FILE: src/cse_pkg.sv
// Package for the CAN signal extract and scale block.
// Holds widths, register codes, reset values and the types shared by the modules.
// Depends on nothing.
package cse_pkg;

    // Fixed widths of the frame, the register port and the result fields
    localparam int FRAME_W = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SCALE_W = 32;
    localparam int VALUE_W = 32;
    localparam int FRAC_BITS = 16;

    // Default parameter values
    localparam int DEF_PAYLOAD_BYTES = 8;
    localparam int DEF_MAX_SIGNAL_BITS = 32;

    // Pipeline registers from an accepted frame to its result strobe
    localparam int PIPE_DEPTH = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_BIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IS_SIGNED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_OFFSET = 3'd5;

    // Register reset values
    localparam logic [5:0] RST_START_BIT = 6'd0;
    localparam logic [5:0] RST_SIGNAL_LENGTH = 6'd8;
    localparam logic RST_IS_SIGNED = 1'b0;
    localparam logic RST_BIG_ENDIAN = 1'b0;
    localparam logic [SCALE_W-1:0] RST_SCALE_FACTOR = 32'd65536000;
    localparam logic [SCALE_W-1:0] RST_SCALE_OFFSET = 32'd0;

    // Field layout settings used by the extract stage
    typedef struct packed {
        logic [5:0] start_bit;
        logic [5:0] signal_length;
        logic       is_signed;
        logic       big_endian;
    } cse_fmt_t;

    // Result fields that ride along the scaling stages
    typedef struct packed {
        logic [VALUE_W-1:0] raw_value;
        logic               out_of_frame;
    } cse_side_t;

endpackage

FILE: src/cse_extract.sv
// Extract stage: cuts one signal out of a CAN payload in Intel or Motorola order.
// Sign-extends a signed field and flags bits past the payload.
// Depends on cse_pkg.
module cse_extract #(
    parameter int PAYLOAD_BYTES = cse_pkg::DEF_PAYLOAD_BYTES,
    parameter int MAX_SIGNAL_BITS = cse_pkg::DEF_MAX_SIGNAL_BITS,
    localparam int RAW_W = MAX_SIGNAL_BITS + 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [cse_pkg::FRAME_W-1:0]       frame_data,
    input  cse_pkg::cse_fmt_t                 fmt,
    output logic                              out_valid,
    output logic signed [RAW_W-1:0]           raw,
    output cse_pkg::cse_side_t                side
);

    localparam int FIELD_W = MAX_SIGNAL_BITS;
    localparam int IDX_W = $clog2(FIELD_W);
    localparam int PL_BITS = PAYLOAD_BYTES * 8;
    localparam logic [cse_pkg::FRAME_W-1:0] PL_MASK =
        {cse_pkg::FRAME_W{1'b1}} >> (cse_pkg::FRAME_W - PL_BITS);

    // Reverse byte order of the payload word
    function automatic logic [cse_pkg::FRAME_W-1:0] swap_bytes(
        input logic [cse_pkg::FRAME_W-1:0] v
    );
        logic [cse_pkg::FRAME_W-1:0] r;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            r[8*i +: 8] = v[8*(7-i) +: 8];
        end
        return r;
    endfunction

    logic [cse_pkg::FRAME_W-1:0] data;
    logic [cse_pkg::FRAME_W-1:0] intel_word;
    logic [cse_pkg::FRAME_W-1:0] moto_word;
    logic [5:0]                  msb_lin;
    logic [5:0]                  first_bit;
    logic                        len_ok;
    logic [FIELD_W-1:0]          field;
    logic [RAW_W-1:0]            fmask;
    logic                        sign_bit;
    logic [RAW_W-1:0]            raw_ext;
    logic                        oof;
    logic                        valid_reg;
    logic signed [RAW_W-1:0]     raw_reg;
    logic                        oof_reg;

    // Drop payload bytes past the frame length
    assign data = frame_data & PL_MASK;
    assign len_ok = (fmt.signal_length != 6'd0) &&
                    ({1'b0, fmt.signal_length} <= 7'(MAX_SIGNAL_BITS));

    // Motorola start bit names the MSB in sawtooth numbering
    assign msb_lin = fmt.start_bit ^ 6'd7;
    assign first_bit = fmt.big_endian ? msb_lin : fmt.start_bit;

    // Align the field at bit zero in either byte order
    assign intel_word = data >> fmt.start_bit;
    assign moto_word = (swap_bytes(data) << msb_lin) >> (7'd64 - {1'b0, fmt.signal_length});

    assign fmask = (RAW_W'(1) << fmt.signal_length) - RAW_W'(1);
    assign field = (fmt.big_endian ? moto_word[FIELD_W-1:0] : intel_word[FIELD_W-1:0])
                   & fmask[FIELD_W-1:0];
    assign sign_bit = field[IDX_W'(fmt.signal_length - 6'd1)];

    // Sign-extend by filling the bits above the field
    always_comb
    begin
        raw_ext = {1'b0, field};
        if (fmt.is_signed && sign_bit)
        begin
            raw_ext = {1'b0, field} | ~fmask;
        end
        if (!len_ok)
        begin
            raw_ext = '0;
        end
    end

    assign oof = len_ok &&
                 (({1'b0, first_bit} + {1'b0, fmt.signal_length}) > 7'(PL_BITS));

    // Hold the extracted beat for the multiplier
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg <= raw_ext;
        oof_reg <= oof;
    end

    assign out_valid = valid_reg;
    assign raw = raw_reg;
    assign side.raw_value = cse_pkg::VALUE_W'(raw_reg);
    assign side.out_of_frame = oof_reg;

`ifndef SYNTH
    // A length outside the supported range gives an empty field in frame
    a_bad_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && ($past(fmt.signal_length) == 6'd0 ||
                       {1'b0, $past(fmt.signal_length)} > 7'(MAX_SIGNAL_BITS)))
        |-> (raw_reg == '0 && !oof_reg))
        else $error("invalid length gave a nonzero field");

    // An unsigned field never comes out negative
    a_unsigned_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !$past(fmt.is_signed)) |-> !raw_reg[RAW_W-1])
        else $error("unsigned field came out negative");
`endif

endmodule

FILE: src/cse_mult.sv
// Multiply stage: raw field times the Q16.16 scale factor.
// Carries the result side fields one stage along. Depends on cse_pkg.
module cse_mult #(
    parameter int MAX_SIGNAL_BITS = cse_pkg::DEF_MAX_SIGNAL_BITS,
    localparam int RAW_W = MAX_SIGNAL_BITS + 1,
    localparam int PROD_W = RAW_W + cse_pkg::SCALE_W
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [RAW_W-1:0]            raw,
    input  cse_pkg::cse_side_t                 in_side,
    input  logic signed [cse_pkg::SCALE_W-1:0] scale_factor,
    output logic                               out_valid,
    output logic signed [PROD_W-1:0]           prod,
    output cse_pkg::cse_side_t                 out_side
);

    logic                    valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    cse_pkg::cse_side_t      side_reg;

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Register the full-width product
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(raw) * PROD_W'(scale_factor);
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign prod = prod_reg;
    assign out_side = side_reg;

endmodule

FILE: src/cse_round.sv
// Offset, truncate and saturate stages: adds the offset, divides by 2^16 toward
// zero and clamps to 32 bits. Depends on cse_pkg.
module cse_round #(
    parameter int MAX_SIGNAL_BITS = cse_pkg::DEF_MAX_SIGNAL_BITS,
    localparam int RAW_W = MAX_SIGNAL_BITS + 1,
    localparam int PROD_W = RAW_W + cse_pkg::SCALE_W
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic signed [PROD_W-1:0]           prod,
    input  cse_pkg::cse_side_t                 in_side,
    input  logic signed [cse_pkg::SCALE_W-1:0] scale_offset,
    output logic                               out_valid,
    output logic [cse_pkg::VALUE_W-1:0]        channel_value,
    output cse_pkg::cse_side_t                 out_side
);

    localparam int QW = PROD_W - cse_pkg::FRAC_BITS;
    localparam int VW = cse_pkg::VALUE_W;

    logic                     acc_valid_reg;
    logic signed [PROD_W-1:0] acc_reg;
    cse_pkg::cse_side_t       acc_side_reg;
    logic [PROD_W-1:0]        bias;
    logic [PROD_W-1:0]        biased;
    logic [QW-1:0]            quot;
    logic [VW-1:0]            sat;
    logic                     out_valid_reg;
    logic [VW-1:0]            channel_reg;
    cse_pkg::cse_side_t       out_side_reg;

    // Advance the valid bits of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_valid_reg <= in_valid;
            out_valid_reg <= acc_valid_reg;
        end
    end

    // Add the offset
    always_ff @(posedge clk)
    begin
        acc_reg <= prod + PROD_W'(scale_offset);
        acc_side_reg <= in_side;
    end

    // Round a negative sum up before the shift so the quotient truncates toward zero
    assign bias = {{(PROD_W - cse_pkg::FRAC_BITS){1'b0}},
                   {cse_pkg::FRAC_BITS{acc_reg[PROD_W-1]}}};
    assign biased = acc_reg + bias;
    assign quot = biased[PROD_W-1:cse_pkg::FRAC_BITS];

    // Clamp to the signed 32-bit range
    generate
        if (QW > VW)
        begin : g_clamp
            always_comb
            begin
                sat = quot[VW-1:0];
                if (quot[QW-1] && !(&quot[QW-1:VW-1]))
                begin
                    sat = {1'b1, {(VW-1){1'b0}}};
                end
                else if (!quot[QW-1] && (|quot[QW-1:VW-1]))
                begin
                    sat = {1'b0, {(VW-1){1'b1}}};
                end
            end
        end
        else
        begin : g_extend
            assign sat = VW'(signed'(quot));
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        channel_reg <= sat;
        out_side_reg <= acc_side_reg;
    end

    assign out_valid = out_valid_reg;
    assign channel_value = channel_reg;
    assign out_side = out_side_reg;

`ifndef SYNTH
    // A negative sum never gives a positive channel value
    a_neg_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && $past(acc_reg[PROD_W-1]))
        |-> (channel_reg[VW-1] || channel_reg == '0))
        else $error("negative sum gave a positive channel value");
`endif

endmodule

FILE: src/can_signal_extract_scale.sv
// Top level of the CAN signal extract and scale block: register file and pipeline.
// Depends on cse_pkg, cse_extract, cse_mult and cse_round.
//
// Usage:
//   Frames enter on start with frame_data; a beat is taken at every rising edge
//   where start is high and busy is low. busy stays low: a frame may enter in
//   every cycle, so the sustained rate is one frame per cycle.
//   Each result beat passes four stages in order: field extract, scale multiply,
//   offset add, truncate and clamp. It appears on raw_value, channel_value and
//   out_of_frame, with done high for a single cycle. Results come out in frame
//   order. The receiver cannot stall; done beats must be taken as they come.
//   Registers are written through cfg_write, cfg_addr and cfg_wdata, one per
//   cycle. The user must write them only while no frame is in flight; the
//   block does not enforce this. Addresses 6 and 7 are ignored. Reset clears
//   the pipeline, so no result beat follows, and loads the register defaults:
//   start bit 0, length 8, unsigned, Intel order, factor 1000.0 and offset 0.
module can_signal_extract_scale #(
    parameter int PAYLOAD_BYTES = cse_pkg::DEF_PAYLOAD_BYTES,
    parameter int MAX_SIGNAL_BITS = cse_pkg::DEF_MAX_SIGNAL_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [cse_pkg::FRAME_W-1:0]      frame_data,
    output logic                             done,
    output logic [cse_pkg::VALUE_W-1:0]      raw_value,
    output logic [cse_pkg::VALUE_W-1:0]      channel_value,
    output logic                             out_of_frame,
    input  logic                             cfg_write,
    input  logic [cse_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [cse_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int RAW_W = MAX_SIGNAL_BITS + 1;
    localparam int PROD_W = RAW_W + cse_pkg::SCALE_W;

    logic [5:0]                        start_bit_reg;
    logic [5:0]                        signal_length_reg;
    logic                              is_signed_reg;
    logic                              big_endian_reg;
    logic signed [cse_pkg::SCALE_W-1:0] scale_factor_reg;
    logic signed [cse_pkg::SCALE_W-1:0] scale_offset_reg;

    logic                     accept;
    cse_pkg::cse_fmt_t        fmt;
    logic                     ext_valid;
    logic signed [RAW_W-1:0]  ext_raw;
    cse_pkg::cse_side_t       ext_side;
    logic                     mul_valid;
    logic signed [PROD_W-1:0] mul_prod;
    cse_pkg::cse_side_t       mul_side;
    cse_pkg::cse_side_t       res_side;

    // The pipeline takes a beat in every cycle
    assign busy = 1'b0;
    assign accept = start && !busy;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_bit_reg <= cse_pkg::RST_START_BIT;
            signal_length_reg <= cse_pkg::RST_SIGNAL_LENGTH;
            is_signed_reg <= cse_pkg::RST_IS_SIGNED;
            big_endian_reg <= cse_pkg::RST_BIG_ENDIAN;
            scale_factor_reg <= cse_pkg::RST_SCALE_FACTOR;
            scale_offset_reg <= cse_pkg::RST_SCALE_OFFSET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                cse_pkg::CFG_START_BIT:     start_bit_reg <= cfg_wdata[5:0];
                cse_pkg::CFG_SIGNAL_LENGTH: signal_length_reg <= cfg_wdata[5:0];
                cse_pkg::CFG_IS_SIGNED:     is_signed_reg <= cfg_wdata[0];
                cse_pkg::CFG_BIG_ENDIAN:    big_endian_reg <= cfg_wdata[0];
                cse_pkg::CFG_SCALE_FACTOR:  scale_factor_reg <= cfg_wdata;
                cse_pkg::CFG_SCALE_OFFSET:  scale_offset_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign fmt.start_bit = start_bit_reg;
    assign fmt.signal_length = signal_length_reg;
    assign fmt.is_signed = is_signed_reg;
    assign fmt.big_endian = big_endian_reg;

    // Extract stage
    cse_extract #(
        .PAYLOAD_BYTES   (PAYLOAD_BYTES),
        .MAX_SIGNAL_BITS (MAX_SIGNAL_BITS)
    ) u_extract (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .frame_data (frame_data),
        .fmt        (fmt),
        .out_valid  (ext_valid),
        .raw        (ext_raw),
        .side       (ext_side)
    );

    // Multiply stage
    cse_mult #(
        .MAX_SIGNAL_BITS (MAX_SIGNAL_BITS)
    ) u_mult (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (ext_valid),
        .raw          (ext_raw),
        .in_side      (ext_side),
        .scale_factor (scale_factor_reg),
        .out_valid    (mul_valid),
        .prod         (mul_prod),
        .out_side     (mul_side)
    );

    // Offset, truncate and clamp stages
    cse_round #(
        .MAX_SIGNAL_BITS (MAX_SIGNAL_BITS)
    ) u_round (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (mul_valid),
        .prod          (mul_prod),
        .in_side       (mul_side),
        .scale_offset  (scale_offset_reg),
        .out_valid     (done),
        .channel_value (channel_value),
        .out_side      (res_side)
    );

    assign raw_value = res_side.raw_value;
    assign out_of_frame = res_side.out_of_frame;

`ifndef SYNTH
    // Every result beat comes from a frame taken a pipeline depth earlier
    a_done_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, cse_pkg::PIPE_DEPTH))
        else $error("result beat without a matching frame");

    // A frame taken now gives its result beat a pipeline depth later
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && $past(rst_n, 1)) |-> ##4 (done || !$past(rst_n, 3)))
        else $error("frame taken but no result beat");
`endif

endmodule

FILE: tb/can_signal_extract_scale_test.sv
`timescale 1ns / 100ps
// Testbench for can_signal_extract_scale: a directed table, then random frames under changing
// register settings, each result beat checked against a typed table value or a signal decode predictor.
// Depends on cse_pkg and the can_signal_extract_scale RTL.
module can_signal_extract_scale_test;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 12;
    localparam int PAYLOAD_BITS = cse_pkg::DEF_PAYLOAD_BYTES * 8;
    localparam int RANDOM_FRAMES = 1030;
    localparam int MAX_REPORTS = 10;
    localparam int FRAC_SCALE = 1 << cse_pkg::FRAC_BITS;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    // Register indexes that the block must ignore
    localparam logic [cse_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [cse_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        cse_pkg::cse_fmt_t           fmt;
        logic [cse_pkg::SCALE_W-1:0] factor;
        logic [cse_pkg::SCALE_W-1:0] offset;
    } decode_cfg_t;

    typedef struct packed {
        logic [cse_pkg::VALUE_W-1:0] raw_value;
        logic [cse_pkg::VALUE_W-1:0] channel_value;
        logic                        out_of_frame;
    } decode_res_t;

    typedef struct {
        decode_cfg_t                 cfg;
        logic [cse_pkg::FRAME_W-1:0] frame;
        bit                          typed;
        decode_res_t                 res;
    } stim_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    logic [cse_pkg::FRAME_W-1:0]    frame_data = '0;
    logic                           cfg_write = 1'b0;
    logic [cse_pkg::CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [cse_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           busy;
    logic                           done;
    logic [cse_pkg::VALUE_W-1:0]    raw_value;
    logic [cse_pkg::VALUE_W-1:0]    channel_value;
    logic                           out_of_frame;

    decode_cfg_t live_cfg;
    decode_res_t pending_q[$];
    stim_row_t   stim_rows[$];
    int          mismatches = 0;
    int          sender_idle_pct = 0;

    can_signal_extract_scale u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .frame_data   (frame_data),
        .done         (done),
        .raw_value    (raw_value),
        .channel_value(channel_value),
        .out_of_frame (out_of_frame),
        .cfg_write    (cfg_write),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // Cut the signal out of one frame and scale it
    function automatic decode_res_t decode_signal(input decode_cfg_t c,
                                                  input logic [cse_pkg::FRAME_W-1:0] frame);
        decode_res_t                 r;
        logic [cse_pkg::FRAME_W-1:0] swapped;
        logic [cse_pkg::FRAME_W-1:0] field;
        logic [cse_pkg::FRAME_W-1:0] fmask;
        int                          len;
        int                          sb;
        int                          msb;
        longint                      raw;
        longint                      acc;
        longint                      q;
        len = int'(c.fmt.signal_length);
        sb = int'(c.fmt.start_bit);
        raw = 0;
        r.out_of_frame = 1'b0;
        // Lengths outside 1..max leave the raw field at zero
        if (len >= 1 && len <= cse_pkg::DEF_MAX_SIGNAL_BITS)
        begin
            fmask = (64'd1 << len) - 64'd1;
            if (c.fmt.big_endian)
            begin
                // Motorola: start bit is the MSB in sawtooth numbering
                msb = (sb / 8) * 8 + 7 - (sb % 8);
                for (int i = 0; i < 8; i++)
                    swapped[8*(7-i) +: 8] = frame[8*i +: 8];
                field = ((swapped << msb) >> (64 - len)) & fmask;
                r.out_of_frame = (msb + len - 1 >= PAYLOAD_BITS);
            end
            else
            begin
                field = (frame >> sb) & fmask;
                r.out_of_frame = (sb + len > PAYLOAD_BITS);
            end
            raw = longint'(field);
            if (c.fmt.is_signed && field[len-1])
                raw -= longint'(64'd1 << len);
        end
        // Scale exactly, truncate toward zero, clamp to 32 bits
        acc = raw * longint'($signed(c.factor)) + longint'($signed(c.offset));
        q = acc / FRAC_SCALE;
        if (q > SAT_HI)
            q = SAT_HI;
        if (q < SAT_LO)
            q = SAT_LO;
        r.raw_value = raw[cse_pkg::VALUE_W-1:0];
        r.channel_value = q[cse_pkg::VALUE_W-1:0];
        return r;
    endfunction

    function automatic logic [cse_pkg::SCALE_W-1:0] pick_scale();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3, 4: return $urandom;
            default: return $urandom_range(2 * 65536000, 0) - 65536000;
        endcase
    endfunction

    // Random settings, biased toward the edges of each register
    function automatic decode_cfg_t pick_settings();
        decode_cfg_t c;
        case ($urandom_range(5))
            0: c.fmt.start_bit = 6'd0;
            1: c.fmt.start_bit = 6'd63;
            default: c.fmt.start_bit = 6'($urandom_range(63));
        endcase
        case ($urandom_range(9))
            0: c.fmt.signal_length = 6'd1;
            1: c.fmt.signal_length = 6'd32;
            2: c.fmt.signal_length = 6'($urandom_range(63, 33));
            3: c.fmt.signal_length = 6'd0;
            default: c.fmt.signal_length = 6'($urandom_range(32, 1));
        endcase
        c.fmt.is_signed = 1'($urandom_range(1));
        c.fmt.big_endian = 1'($urandom_range(1));
        c.factor = pick_scale();
        c.offset = pick_scale();
        return c;
    endfunction

    function automatic logic [cse_pkg::FRAME_W-1:0] pick_frame();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(63);
            3: return ~(64'd1 << $urandom_range(63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic log_failure(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("%0t %s", $time, msg);
        mismatches++;
    endtask

    task automatic add_row(input int sb, input int len, input bit sgn, input bit be,
                           input logic [cse_pkg::SCALE_W-1:0] factor,
                           input logic [cse_pkg::SCALE_W-1:0] offset,
                           input logic [cse_pkg::FRAME_W-1:0] frame, input bit typed,
                           input logic [cse_pkg::VALUE_W-1:0] raw,
                           input logic [cse_pkg::VALUE_W-1:0] chan,
                           input bit oof);
        stim_row_t row;
        row.cfg.fmt.start_bit = sb[5:0];
        row.cfg.fmt.signal_length = len[5:0];
        row.cfg.fmt.is_signed = sgn;
        row.cfg.fmt.big_endian = be;
        row.cfg.factor = factor;
        row.cfg.offset = offset;
        row.frame = frame;
        row.typed = typed;
        row.res.raw_value = raw;
        row.res.channel_value = chan;
        row.res.out_of_frame = oof;
        stim_rows.insert(stim_rows.size(), row);
    endtask

    // Write one register and mirror it into the predictor settings
    task automatic write_reg(input logic [cse_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cse_pkg::CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            cse_pkg::CFG_START_BIT: live_cfg.fmt.start_bit = data[5:0];
            cse_pkg::CFG_SIGNAL_LENGTH: live_cfg.fmt.signal_length = data[5:0];
            cse_pkg::CFG_IS_SIGNED: live_cfg.fmt.is_signed = data[0];
            cse_pkg::CFG_BIG_ENDIAN: live_cfg.fmt.big_endian = data[0];
            cse_pkg::CFG_SCALE_FACTOR: live_cfg.factor = data;
            cse_pkg::CFG_SCALE_OFFSET: live_cfg.offset = data;
            default: ;
        endcase
    endtask

    task automatic load_settings(input decode_cfg_t c);
        logic [cse_pkg::CFG_DATA_W-1:0] junk;
        // Stray bits above a narrow register must be dropped
        junk = ($urandom_range(3) == 0) ? $urandom : '0;
        write_reg(cse_pkg::CFG_START_BIT, {junk[31:6], c.fmt.start_bit});
        write_reg(cse_pkg::CFG_SIGNAL_LENGTH, {junk[31:6], c.fmt.signal_length});
        write_reg(cse_pkg::CFG_IS_SIGNED, {junk[31:1], c.fmt.is_signed});
        write_reg(cse_pkg::CFG_BIG_ENDIAN, {junk[31:1], c.fmt.big_endian});
        write_reg(cse_pkg::CFG_SCALE_FACTOR, c.factor);
        write_reg(cse_pkg::CFG_SCALE_OFFSET, c.offset);
        if ($urandom_range(1))
            write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
        cfg_write <= 1'b0;
    endtask

    // Hold off frames until every expected result has arrived
    task automatic drain_results();
        start <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Offer one frame, record its expected result, then idle at random
    task automatic send_frame(input logic [cse_pkg::FRAME_W-1:0] frame, input bit typed,
                              input decode_res_t res);
        start <= 1'b1;
        frame_data <= frame;
        do
            @(posedge clk);
        while (busy);
        pending_q.insert(pending_q.size(), typed ? res : decode_signal(live_cfg, frame));
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin : result_check
        decode_res_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_q.size() == 0)
            begin
                log_failure($sformatf("unexpected beat: raw %h channel %h out_of_frame %b",
                                      raw_value, channel_value, out_of_frame));
            end
            else
            begin
                want = pending_q.pop_front();
                if (raw_value !== want.raw_value || channel_value !== want.channel_value ||
                    out_of_frame !== want.out_of_frame)
                    log_failure($sformatf({"mismatch: raw %h/%h channel %h/%h ",
                                           "out_of_frame %b/%b (expected/actual)"},
                                          want.raw_value, raw_value, want.channel_value,
                                          channel_value, want.out_of_frame, out_of_frame));
            end
        end
    end

    initial
    begin
        #(2 * HALF_PERIOD * 400_000);
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        decode_res_t blank_res;
        int          sent;
        int          phase;
        blank_res = '0;
        live_cfg.fmt.start_bit = cse_pkg::RST_START_BIT;
        live_cfg.fmt.signal_length = cse_pkg::RST_SIGNAL_LENGTH;
        live_cfg.fmt.is_signed = cse_pkg::RST_IS_SIGNED;
        live_cfg.fmt.big_endian = cse_pkg::RST_BIG_ENDIAN;
        live_cfg.factor = cse_pkg::RST_SCALE_FACTOR;
        live_cfg.offset = cse_pkg::RST_SCALE_OFFSET;

        // Reset defaults: one byte at bit 0, factor 1000
        add_row(0, 8, 0, 0, 65536000, 0, 64'h0123_4567_89AB_CDA5, 1, 32'hA5, 32'd165000, 0);
        add_row(0, 8, 0, 0, 65536000, 0, 64'h0, 1, 32'h0, 32'h0, 0);
        add_row(0, 8, 0, 0, 65536000, 0, '1, 1, 32'hFF, 32'd255000, 0);
        // Full width, unsigned saturates high, signed gives minus one
        add_row(0, 32, 0, 0, 65536000, 0, '1, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
        add_row(0, 32, 1, 0, 65536000, 0, '1, 1, 32'hFFFF_FFFF, -32'sd1000, 0);
        // Most negative field times largest factor clamps low
        add_row(0, 32, 1, 0, 32'h7FFF_FFFF, 0, 64'h8000_0000, 1, 32'h8000_0000,
                32'h8000_0000, 0);
        // A tiny negative product truncates toward zero
        add_row(0, 8, 1, 0, 1, 0, 64'hFF, 1, 32'hFFFF_FFFF, 32'h0, 0);
        // Intel signal running past the payload
        add_row(63, 2, 0, 0, 65536000, 0, '1, 1, 32'h1, 32'd1000, 1);
        // Motorola byte 0, and a Motorola signal running past the payload
        add_row(7, 8, 0, 1, 65536000, 0, 64'hA5, 1, 32'hA5, 32'd165000, 0);
        add_row(56, 2, 0, 1, 65536000, 0, '1, 1, 32'h2, 32'd2000, 1);
        // Length zero and length above the maximum give the offset alone
        add_row(0, 0, 0, 0, 65536000, 32'h7FFF_FFFF, '1, 1, 32'h0, 32'h7FFF, 0);
        add_row(0, 63, 0, 0, 65536000, 32'hFFFB_0000, 64'hDEAD_BEEF_0BAD_F00D, 1, 32'h0,
                32'hFFFF_FFFB, 0);
        add_row(0, 33, 1, 1, 65536000, 32'h0001_2345, '1, 0, 0, 0, 0);
        // Unsigned full width times most negative factor and offset
        add_row(0, 32, 0, 1, 32'h8000_0000, 32'h8000_0000, '1, 1, 32'hFFFF_FFFF,
                32'h8000_0000, 0);
        add_row(0, 1, 1, 0, 65536000, 0, 64'h1, 0, 0, 0, 0);
        add_row(37, 20, 1, 1, 32'h0001_8000, 32'hFFFF_0000, 64'h5A3C_96E1_0F87_C3D2, 0, 0, 0, 0);
        add_row(60, 8, 1, 0, 32'hFFF0_0000, 32'h0000_7FFF, 64'hF000_0000_0000_0000, 0, 0, 0, 0);
        add_row(63, 32, 1, 1, 65536000, 0, 64'h7F00_0000_0000_0080, 0, 0, 0, 0);
        add_row(31, 16, 0, 1, 32'h0001_0000, 32'h0000_8000, 64'h1234_5678_9ABC_DEF0, 0, 0, 0, 0);
        add_row(0, 8, 0, 0, 0, 32'h8000_0000, 64'h55AA_55AA_55AA_55AA, 0, 0, 0, 0);
        add_row(0, 8, 0, 0, 65536000, 0, 64'hFEDC_BA98_7654_3210, 0, 0, 0, 0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table, rewriting registers only when a row changes them
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].cfg != live_cfg)
            begin
                drain_results();
                load_settings(stim_rows[i].cfg);
            end
            send_frame(stim_rows[i].frame, stim_rows[i].typed, stim_rows[i].res);
        end

        // Random frames in phases, each with fresh settings and its own idle rate
        sent = 0;
        phase = 0;
        while (sent < RANDOM_FRAMES)
        begin
            drain_results();
            case (phase % 3)
                0: sender_idle_pct = 0;
                1: sender_idle_pct = 55;
                default: sender_idle_pct = 11;
            endcase
            load_settings(pick_settings());
            repeat ($urandom_range(100, 40))
            begin
                if ($urandom_range(49) == 0)
                    drain_results();
                send_frame(pick_frame(), 1'b0, blank_res);
                sent++;
            end
            phase++;
        end

        // Let the pipeline empty, then watch for stray beats
        drain_results();
        repeat (4 * cse_pkg::PIPE_DEPTH) @(posedge clk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: can_signal_extract_scale.f
src/cse_pkg.sv
src/cse_extract.sv
src/cse_mult.sv
src/cse_round.sv
src/can_signal_extract_scale.sv
tb/can_signal_extract_scale_test.sv
